[rtl/core/oaat_pkg.sv]
// Package for the one-at-a-time hash index block: item types, states, ALU codes, constants.
package oaat_pkg;

  localparam int unsigned HASH_W      = 64;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SIZE_W      = 32;
  localparam int unsigned SHAMT_W     = 4;
  localparam int unsigned DIV_STEPS   = HASH_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [SHAMT_W-1:0] MIX_LEFT    = SHAMT_W'(10);
  localparam logic [SHAMT_W-1:0] MIX_RIGHT   = SHAMT_W'(6);
  localparam logic [SHAMT_W-1:0] FIN_LEFT_A  = SHAMT_W'(3);
  localparam logic [SHAMT_W-1:0] FIN_RIGHT   = SHAMT_W'(11);
  localparam logic [SHAMT_W-1:0] FIN_LEFT_B  = SHAMT_W'(15);

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(1);

  typedef struct packed {
    logic [BYTE_W-1:0] key_byte;
    logic              byte_valid;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] bucket_index;
    logic              size_error;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIX_SHL,
    ST_MIX_SHR,
    ST_FIN_A,
    ST_FIN_R,
    ST_FIN_B,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_ADD_BYTE,
    OP_ADD_SHL,
    OP_XOR_SHR
  } alu_op_t;

endpackage

[rtl/core/one_at_a_time_hash_index.sv]
// Top level: one-at-a-time hash over a byte stream, reduced modulo a configured table size.
//
// Usage: feed the key one byte per item on in_valid/in_ready. byte_valid marks a byte that
// belongs to the key; last_byte ends the key and yields one result on out_valid/out_ready:
// bucket_index = hash % table_size, or size_error with index 0 when table_size is zero.
// Other items give no result. table_size is written through cfg_valid/cfg_ready/cfg_data
// (always ready); write it only while the block is idle, which the block does not enforce.
// Sequencing: all work runs through one 64-bit add/xor/shift unit and one 32-bit
// compare-subtract stage under a small sequencer, and in_ready is low while it runs.
// A valid non-last byte is accepted with the add, then takes two mixing steps; an
// invalid non-last byte is only accepted. A last item runs the same steps for its byte,
// if any, then three finalize steps, 64 restoring-division steps and a load of the output
// register, which waits while the previous result is still held; with a zero table size
// the division is skipped.
// A result waiting in the output register does not block mixing of the next key; only
// the next result waits until the receiver takes the previous one.
// Reset (rst, synchronous) clears the accumulator, returns to idle, drops any pending
// result and sets table_size to 1.
module one_at_a_time_hash_index
  import oaat_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data
);

  state_t                state, state_next;
  logic [HASH_W-1:0]     acc, acc_next;
  logic [SIZE_W-1:0]     rem, rem_next;
  logic [DIV_CNT_W-1:0]  count;
  logic [SIZE_W-1:0]     table_size;
  logic                  last_r;

  alu_op_t               alu_op;
  logic [SHAMT_W-1:0]    shamt;
  logic [HASH_W-1:0]     alu_operand;
  logic [HASH_W-1:0]     alu_result;

  logic [SIZE_W:0]       rem_shift;
  logic [SIZE_W+1:0]     rem_diff;

  logic                  in_fire;
  logic                  out_free;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Shared mixing unit.
  always_comb begin
    case (alu_op)
      OP_ADD_BYTE: alu_operand = {{(HASH_W-BYTE_W){1'b0}}, in_data.key_byte};
      OP_ADD_SHL:  alu_operand = acc << shamt;
      OP_XOR_SHR:  alu_operand = acc >> shamt;
      default:     alu_operand = '0;
    endcase
    if (alu_op == OP_XOR_SHR) begin
      alu_result = acc ^ alu_operand;
    end else begin
      alu_result = acc + alu_operand;
    end
  end

  // Restoring division step.
  assign rem_shift = {rem, acc[HASH_W-1]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b00, table_size};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.byte_valid) begin
            state_next = ST_MIX_SHL;
          end else if (in_data.last_byte) begin
            state_next = ST_FIN_A;
          end
        end
      end
      ST_MIX_SHL: state_next = ST_MIX_SHR;
      ST_MIX_SHR: state_next = last_r ? ST_FIN_A : ST_IDLE;
      ST_FIN_A:   state_next = ST_FIN_R;
      ST_FIN_R:   state_next = ST_FIN_B;
      ST_FIN_B:   state_next = (table_size == '0) ? ST_DONE : ST_DIV;
      ST_DIV: begin
        if (count == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Unit control and datapath next values.
  always_comb begin
    alu_op   = OP_PASS;
    shamt    = '0;
    acc_next = acc;
    rem_next = rem;
    case (state)
      ST_IDLE: begin
        alu_op = OP_ADD_BYTE;
        if (in_fire && in_data.byte_valid) begin
          acc_next = alu_result;
        end
      end
      ST_MIX_SHL: begin
        alu_op   = OP_ADD_SHL;
        shamt    = MIX_LEFT;
        acc_next = alu_result;
      end
      ST_MIX_SHR: begin
        alu_op   = OP_XOR_SHR;
        shamt    = MIX_RIGHT;
        acc_next = alu_result;
      end
      ST_FIN_A: begin
        alu_op   = OP_ADD_SHL;
        shamt    = FIN_LEFT_A;
        acc_next = alu_result;
      end
      ST_FIN_R: begin
        alu_op   = OP_XOR_SHR;
        shamt    = FIN_RIGHT;
        acc_next = alu_result;
      end
      ST_FIN_B: begin
        alu_op   = OP_ADD_SHL;
        shamt    = FIN_LEFT_B;
        acc_next = alu_result;
        rem_next = '0;
      end
      ST_DIV: begin
        acc_next = acc << 1;
        if (!rem_diff[SIZE_W+1]) begin
          rem_next = rem_diff[SIZE_W-1:0];
        end else begin
          rem_next = rem_shift[SIZE_W-1:0];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          acc_next = '0;
        end
      end
      default: begin
        acc_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      acc        <= '0;
      count      <= '0;
      last_r     <= 1'b0;
      table_size <= TABLE_SIZE_RESET;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      acc   <= acc_next;
      if (cfg_valid && cfg_ready) begin
        table_size <= cfg_data;
      end
      if (in_fire) begin
        last_r <= in_data.last_byte;
      end
      if (state == ST_DIV) begin
        count <= count + DIV_CNT_W'(1);
      end else begin
        count <= '0;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem <= rem_next;
    if (state == ST_DONE && out_free) begin
      out_data.size_error   <= (table_size == '0);
      out_data.bucket_index <= (table_size == '0) ? '0 : rem;
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (table_size != '0))
    else $error("division running with zero table size");

  a_err_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.size_error) |-> (out_data.bucket_index == '0))
    else $error("size error result carries nonzero index");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.size_error) |-> (out_data.bucket_index < table_size))
    else $error("bucket index not below table size");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.last_byte && !in_data.byte_valid) |=> (state == ST_FIN_A))
    else $error("last item without byte did not go to finalize");

  a_clear_after_key: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (acc == '0 && out_valid))
    else $error("accumulator not cleared or result not loaded");

endmodule
